// ----- src/arp_pkg.sv -----
// Shared types, codes and defaults for the aligned ring producer.
package arp_pkg;

    localparam int HEADER_BYTES_DEF = 8;
    localparam int OFFSET_BITS_DEF  = 20;

    localparam int LEN_W   = 21;
    localparam int TAIL_W  = 32;
    localparam int FIELD_W = 20;
    localparam int SHIFT_W = 4;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_LINK_READY  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RING_LEN    = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALIGN_SHIFT = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_MSG_LEN = 8'd3;

    localparam logic [LEN_W-1:0]   RING_LEN_RST    = 21'd65536;
    localparam logic [SHIFT_W-1:0] ALIGN_SHIFT_RST = 4'd3;
    localparam logic [LEN_W-1:0]   MAX_MSG_LEN_RST = 21'd4096;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_READY  = 3'd1,
        ST_ZERO_LEN   = 3'd2,
        ST_OVERSIZE   = 3'd3,
        ST_CONS_RESET = 3'd4,
        ST_NO_SPACE   = 3'd5
    } status_t;

    typedef struct packed {
        logic               link_ready;
        logic [LEN_W-1:0]   ring_len;
        logic [SHIFT_W-1:0] align_shift;
        logic [LEN_W-1:0]   max_msg_len;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   need_bytes;
        logic [FIELD_W-1:0] header_offset;
        logic [FIELD_W-1:0] header_size_field;
        logic [FIELD_W-1:0] payload_offset;
        logic [LEN_W-1:0]   first_len;
        logic [LEN_W-1:0]   second_len;
        logic [FIELD_W-1:0] new_head;
        logic               kick;
    } result_t;

endpackage

// ----- src/arp_calc.sv -----
// Send request checks, offset placement, wrap split and head advance.
module arp_calc
    import arp_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF
)
(
    input  cfg_t                   cfg,
    input  logic [OFFSET_BITS-1:0] head,
    input  logic [LEN_W-1:0]       msg_len,
    input  logic [TAIL_W-1:0]      cons_tail,
    output result_t                result,
    output logic [OFFSET_BITS-1:0] head_next
);

    localparam int WIDE_W = (OFFSET_BITS > 22) ? OFFSET_BITS : 22;
    localparam int CALC_W = WIDE_W + 3;
    localparam logic [CALC_W-1:0] OFF_MASK =
        {{(CALC_W-OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};
    localparam logic [CALC_W-1:0] LEN_MAX = CALC_W'({LEN_W{1'b1}});

    function automatic logic [CALC_W-1:0] align_up(
        input logic [CALC_W-1:0]  x,
        input logic [SHIFT_W-1:0] sh
    );
        logic [CALC_W-1:0] m;
        m = CALC_W'((17'd1 << sh) - 17'd1);
        return (x + m) & ~m;
    endfunction

    logic [CALC_W-1:0] n_w;
    logic [CALC_W-1:0] ring_w;
    logic [CALC_W-1:0] head_w;
    logic [CALC_W-1:0] tail_w;
    logic [CALC_W-1:0] need;
    logic [CALC_W-1:0] used;
    logic [CALC_W-1:0] avail;
    logic [CALC_W-1:0] off_raw;
    logic [CALC_W-1:0] off;
    logic [CALC_W-1:0] off_m;
    logic [CALC_W-1:0] end_w;
    logic [CALC_W-1:0] first_w;
    logic [CALC_W-1:0] nh_raw;
    logic [CALC_W-1:0] nh;
    logic              tail_bad;
    logic              room_ok;

    always_comb
    begin
        n_w    = CALC_W'(msg_len);
        ring_w = CALC_W'(cfg.ring_len);
        head_w = CALC_W'(head);
        // only used once the tail is known to lie inside the ring
        tail_w = CALC_W'(cons_tail[LEN_W-1:0]);

        need = align_up(CALC_W'(HEADER_BYTES), cfg.align_shift)
             + align_up(n_w, cfg.align_shift);

        tail_bad = cons_tail >= TAIL_W'(cfg.ring_len);

        // room when avail - head - 1 >= need, kept unsigned
        used  = head_w + CALC_W'(1) + need;
        avail = (head_w < tail_w) ? tail_w : ring_w + tail_w;
        room_ok = avail >= used;

        off_raw = align_up(head_w + CALC_W'(HEADER_BYTES), cfg.align_shift);
        off = (off_raw >= ring_w) ? off_raw - ring_w : off_raw;
        off_m = off & OFF_MASK;

        end_w = off + n_w;
        if (end_w <= ring_w)
        begin
            first_w = n_w;
        end
        else
        begin
            first_w = (ring_w > off) ? ring_w - off : '0;
        end

        nh_raw = align_up(end_w, cfg.align_shift);
        nh = ((nh_raw >= ring_w) ? nh_raw - ring_w : nh_raw) & OFF_MASK;
        head_next = nh[OFFSET_BITS-1:0];

        result = '0;
        if (!cfg.link_ready)
        begin
            result.status = ST_NOT_READY;
        end
        else if (msg_len == '0)
        begin
            result.status = ST_ZERO_LEN;
        end
        else if (msg_len > cfg.max_msg_len)
        begin
            result.status = ST_OVERSIZE;
        end
        else
        begin
            result.need_bytes = (need > LEN_MAX) ? {LEN_W{1'b1}} : need[LEN_W-1:0];
            if (tail_bad)
            begin
                result.status = ST_CONS_RESET;
            end
            else if (!room_ok)
            begin
                result.status = ST_NO_SPACE;
            end
            else
            begin
                result.status            = ST_OK;
                result.header_offset     = head_w[FIELD_W-1:0];
                result.header_size_field = 20'(msg_len - 21'd1);
                result.payload_offset    = off_m[FIELD_W-1:0];
                result.first_len         = first_w[LEN_W-1:0];
                result.second_len        = msg_len - first_w[LEN_W-1:0];
                result.new_head          = nh[FIELD_W-1:0];
                result.kick              = cons_tail == TAIL_W'(head);
            end
        end
    end

endmodule

// ----- src/aligned_ring_producer_top.sv -----
// Top level of the aligned ring producer: config registers, head and request pipeline.
//
// Producer side of a shared-memory message ring. Each request on the slave stream
// carries a message length and the consumer's tail offset; one result leaves on the
// master stream per request, with the status code in tuser. The block takes one
// request per clock while the master stream is not stalled. Each request is held
// in the input register, and its result is then loaded into the result register,
// from which it is presented on the master stream. The head register is updated
// in the same cycle that a successful request moves into the result register, so
// the next request always sees the new head. Config writes are taken at any time
// and must be issued only while no request is in flight.
module aligned_ring_producer_top
    import arp_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // msg_len [20:0], cons_tail [52:21], zero pad [55:53]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // need_bytes [20:0], header_offset [40:21], header_size_field [60:41],
    // payload_offset [80:61], first_len [101:81], second_len [122:102],
    // new_head [142:123], kick [143]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status [2:0]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    cfg_t                   cfg_reg;
    logic [OFFSET_BITS-1:0] head_reg;

    logic                   in_valid_reg;
    logic [LEN_W-1:0]       msg_len_reg;
    logic [TAIL_W-1:0]      tail_reg;

    logic                   out_valid_reg;
    result_t                out_reg;

    result_t                result;
    logic [OFFSET_BITS-1:0] head_next;
    logic                   advance;
    logic                   in_take;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_ready  <= 1'b0;
            cfg_reg.ring_len    <= RING_LEN_RST;
            cfg_reg.align_shift <= ALIGN_SHIFT_RST;
            cfg_reg.max_msg_len <= MAX_MSG_LEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                CFG_LINK_READY:  cfg_reg.link_ready  <= cfg_data[0];
                CFG_RING_LEN:    cfg_reg.ring_len    <= cfg_data[LEN_W-1:0];
                CFG_ALIGN_SHIFT: cfg_reg.align_shift <= cfg_data[SHIFT_W-1:0];
                CFG_MAX_MSG_LEN: cfg_reg.max_msg_len <= cfg_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    arp_calc #(
        .HEADER_BYTES (HEADER_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_calc (
        .cfg         (cfg_reg),
        .head        (head_reg),
        .msg_len     (msg_len_reg),
        .cons_tail   (tail_reg),
        .result      (result),
        .head_next   (head_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // advance the head only on a request that was placed in the ring
            if (advance && result.status == ST_OK)
            begin
                head_reg <= head_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            msg_len_reg <= s_axis_tdata[LEN_W-1:0];
            tail_reg    <= s_axis_tdata[LEN_W+TAIL_W-1:LEN_W];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {out_reg.kick, out_reg.new_head, out_reg.second_len,
                            out_reg.first_len, out_reg.payload_offset,
                            out_reg.header_size_field, out_reg.header_offset,
                            out_reg.need_bytes};

endmodule
